[rtl/pcfs_pkg.sv]
// ----------------------------------------------------------------------------
// pcfs_pkg
// Shared widths, codes, register map and controller/datapath interface types
// for the proposal context feature sampler.
// ----------------------------------------------------------------------------
package pcfs_pkg;

  localparam int unsigned SAMPLE_W   = 16;
  localparam int unsigned POS_W      = 7;
  localparam int unsigned POINT_W    = 8;
  localparam int unsigned LEN_W      = 8;
  localparam int unsigned CNT_W      = 7;
  localparam int unsigned FRAC_W     = 16;
  localparam int unsigned APB_DATA_W = 32;
  localparam int unsigned APB_ADDR_W = 4;

  // Divider: 32-bit dividend, two quotient bits per cycle.
  localparam int unsigned DIVIDEND_W = 32;
  localparam int unsigned DIVISOR_W  = 11;
  localparam int unsigned DIV_ITER   = DIVIDEND_W / 2;
  localparam int unsigned DIV_CNT_W  = $clog2(DIV_ITER);

  localparam logic CMD_WRITE = 1'b0;
  localparam logic CMD_QUERY = 1'b1;

  typedef enum logic [1:0] {
    REG_SEQ_LENGTH    = 2'd0,
    REG_START_POINTS  = 2'd1,
    REG_CENTER_POINTS = 2'd2,
    REG_END_POINTS    = 2'd3
  } reg_idx_e;

  localparam logic [LEN_W-1:0] SEQ_LENGTH_RST    = 8'd100;
  localparam logic [CNT_W-1:0] START_POINTS_RST  = 7'd8;
  localparam logic [CNT_W-1:0] CENTER_POINTS_RST = 7'd16;
  localparam logic [CNT_W-1:0] END_POINTS_RST    = 7'd8;

  typedef struct packed {
    logic [LEN_W-1:0] seq_length;
    logic [CNT_W-1:0] start_points;
    logic [CNT_W-1:0] center_points;
    logic [CNT_W-1:0] end_points;
  } cfg_t;

  typedef struct packed {
    logic capture;   // latch query fields
    logic mem_wr;    // write one sample into the sequence store
    logic sel_en;    // register region selection and multiplier operands
    logic mul_en;    // register dividend and divisor
    logic div_en;    // one divider iteration
    logic pos_en;    // register sample indices and fraction
    logic rd_hi;     // read the upper neighbor
    logic s0_en;     // capture the lower neighbor
    logic mac_en;    // register the interpolation product
    logic out_load;  // load the output register
  } dp_cmd_t;

  typedef struct packed {
    logic cmd_query;
    logic masked;
  } dp_status_t;

endpackage

[rtl/pcfs_in_if.sv]
// ----------------------------------------------------------------------------
// pcfs_in_if
// Input channel: sample writes and proposal point queries.
// ----------------------------------------------------------------------------
interface pcfs_in_if;

  logic                                 valid;
  logic                                 ready;
  logic                                 cmd;
  logic signed [pcfs_pkg::SAMPLE_W-1:0] sample_value;
  logic [pcfs_pkg::POS_W-1:0]           sample_pos;
  logic [pcfs_pkg::POS_W-1:0]           start_pos;
  logic [pcfs_pkg::POS_W-1:0]           end_pos;
  logic [pcfs_pkg::POINT_W-1:0]         point_index;

  modport source (
    output valid, cmd, sample_value, sample_pos, start_pos, end_pos, point_index,
    input  ready
  );

  modport sink (
    input  valid, cmd, sample_value, sample_pos, start_pos, end_pos, point_index,
    output ready
  );

endinterface

[rtl/pcfs_out_if.sv]
// ----------------------------------------------------------------------------
// pcfs_out_if
// Output channel: one interpolated feature per query.
// ----------------------------------------------------------------------------
interface pcfs_out_if;

  logic                                 valid;
  logic                                 ready;
  logic signed [pcfs_pkg::SAMPLE_W-1:0] result_value;
  logic                                 masked;

  modport source (
    output valid, result_value, masked,
    input  ready
  );

  modport sink (
    input  valid, result_value, masked,
    output ready
  );

endinterface

[rtl/pcfs_ctrl.sv]
// ----------------------------------------------------------------------------
// pcfs_ctrl
// Sequencer for one query: region select, multiply, iterative divide,
// index calculation, two store reads, interpolation and output hand-off.
// ----------------------------------------------------------------------------
module pcfs_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  input  pcfs_pkg::dp_status_t status_i,
  output pcfs_pkg::dp_cmd_t    cmd_o
);

  typedef enum logic [8:0] {
    ST_IDLE = 9'b000000001,
    ST_SEL  = 9'b000000010,
    ST_MUL  = 9'b000000100,
    ST_DIV  = 9'b000001000,
    ST_POS  = 9'b000010000,
    ST_RD0  = 9'b000100000,
    ST_RD1  = 9'b001000000,
    ST_MAC  = 9'b010000000,
    ST_FIN  = 9'b100000000
  } state_e;

  state_e                           state_q, state_d;
  logic [pcfs_pkg::DIV_CNT_W-1:0]   div_cnt_q, div_cnt_d;
  logic                             out_valid_q, out_valid_d;
  logic                             div_last;

  assign div_last = (div_cnt_q == pcfs_pkg::DIV_CNT_W'(pcfs_pkg::DIV_ITER - 1));

  always_comb begin
    state_d    = state_q;
    div_cnt_d  = div_cnt_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          if (status_i.cmd_query) begin
            cmd_o.capture = 1'b1;
            state_d       = ST_SEL;
          end else begin
            cmd_o.mem_wr = 1'b1;
          end
        end
      end
      ST_SEL: begin
        // An inverted proposal skips the arithmetic entirely.
        if (status_i.masked) begin
          state_d = ST_FIN;
        end else begin
          cmd_o.sel_en = 1'b1;
          state_d      = ST_MUL;
        end
      end
      ST_MUL: begin
        cmd_o.mul_en = 1'b1;
        div_cnt_d    = '0;
        state_d      = ST_DIV;
      end
      ST_DIV: begin
        cmd_o.div_en = 1'b1;
        div_cnt_d    = div_cnt_q + 1'b1;
        if (div_last) begin
          state_d = ST_POS;
        end
      end
      ST_POS: begin
        cmd_o.pos_en = 1'b1;
        state_d      = ST_RD0;
      end
      ST_RD0: begin
        state_d = ST_RD1;
      end
      ST_RD1: begin
        cmd_o.rd_hi = 1'b1;
        cmd_o.s0_en = 1'b1;
        state_d     = ST_MAC;
      end
      ST_MAC: begin
        cmd_o.mac_en = 1'b1;
        state_d      = ST_FIN;
      end
      ST_FIN: begin
        if (!out_valid_q || out_ready_i) begin
          cmd_o.out_load = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.out_load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      div_cnt_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      div_cnt_q   <= div_cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

[rtl/pcfs_datapath.sv]
// ----------------------------------------------------------------------------
// pcfs_datapath
// Sequence store, region arithmetic, radix-4 restoring divider, neighbor
// clamping and linear interpolation with rounding and saturation.
// ----------------------------------------------------------------------------
module pcfs_datapath #(
  parameter int unsigned MAX_LEN = 128
) (
  input  logic                                 clk_i,
  input  pcfs_pkg::cfg_t                       cfg_i,
  input  pcfs_pkg::dp_cmd_t                    cmd_i,
  output pcfs_pkg::dp_status_t                 status_o,
  input  logic                                 in_cmd_i,
  input  logic signed [pcfs_pkg::SAMPLE_W-1:0] sample_value_i,
  input  logic [pcfs_pkg::POS_W-1:0]           sample_pos_i,
  input  logic [pcfs_pkg::POS_W-1:0]           start_pos_i,
  input  logic [pcfs_pkg::POS_W-1:0]           end_pos_i,
  input  logic [pcfs_pkg::POINT_W-1:0]         point_index_i,
  output logic signed [pcfs_pkg::SAMPLE_W-1:0] result_value_o,
  output logic                                 masked_o
);

  localparam int unsigned IDX_W  = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
  localparam int unsigned SW     = pcfs_pkg::SAMPLE_W;
  localparam int unsigned PW     = pcfs_pkg::POS_W;
  localparam int unsigned CW     = pcfs_pkg::CNT_W;
  localparam int unsigned LW     = pcfs_pkg::LEN_W;
  localparam int unsigned FW     = pcfs_pkg::FRAC_W;
  localparam int unsigned NW     = pcfs_pkg::DIVIDEND_W;
  localparam int unsigned DW     = pcfs_pkg::DIVISOR_W;
  localparam int unsigned IW     = LW + 2;      // signed integer part of a position
  localparam int unsigned POSW   = IW + FW;     // signed position
  localparam int unsigned MW     = CW + 2;      // signed multiplier operand
  localparam int unsigned DENW   = DW - 1;      // divisor before doubling
  localparam int unsigned KW     = 2 * MW;      // product width
  localparam int unsigned PRODW  = 2 * (SW + 1);
  localparam int unsigned ACCW   = PRODW + 1;
  localparam int unsigned RESW   = ACCW - FW;
  // Context regions span 2/5 of the proposal length.
  localparam logic [DENW-1:0] CTX_DEN = DENW'(5);
  localparam logic [DENW-1:0] UNIT_DEN = DENW'(1);

  // Sequence store
  logic signed [SW-1:0] seq_mem_q [MAX_LEN];
  logic signed [SW-1:0] rd_data_q;
  logic                 wr_in_range;

  // Query fields
  logic [PW-1:0]      h_q, w_q;
  logic [LW-1:0]      c_q;

  // Region select
  logic [LW-1:0]      sc_sum, end_raw, ctr_raw;
  logic               in_start, in_end;
  logic [CW-1:0]      end_m, end_step, ctx_step, ctx_m, ctr_m, ctr_step;
  logic [PW-1:0]      span;
  logic [LW-1:0]      flen;
  logic signed [MW-1:0] twos;
  logic [DENW-1:0]    den5;
  logic [LW-1:0]      mul_a_d, mul_a_q;
  logic signed [MW-1:0] mul_b_d, mul_b_q;
  logic [DENW-1:0]    den_d, den_q;
  logic [PW-1:0]      base_d, base_q;

  // Multiply and divide
  logic signed [KW-1:0] prod_k;
  logic [KW-1:0]      mag_k;
  logic               neg_k, neg_q;
  logic [NW-1:0]      dividend;
  logic [NW-1:0]      div_q, div_d;
  logic [DW-1:0]      rem_q, rem_d;
  logic [DW-1:0]      d2_q;

  // Position and reads
  logic signed [POSW-1:0] base_ext, q_ext, pos;
  logic signed [IW-1:0]   l0, l1;
  logic [LW-1:0]      lim, last;
  logic [IDX_W-1:0]   idx0_q, idx1_q;
  logic [FW-1:0]      f_q;
  logic signed [SW-1:0] s0_q;

  // Interpolation
  logic signed [SW:0]      diff;
  logic signed [PRODW-1:0] prod_f, mac_q;
  logic signed [ACCW-1:0]  acc;
  logic signed [RESW-1:0]  res_hi;
  logic signed [SW-1:0]    res_sat;
  logic                    masked;

  function automatic logic [LW-1:0] clamp_idx(logic signed [IW-1:0] l,
                                               logic [LW-1:0] hi);
    logic [LW-1:0] r;
    if (l < 0) begin
      r = '0;
    end else if (l > $signed({2'b00, hi})) begin
      r = hi;
    end else begin
      r = l[LW-1:0];
    end
    return r;
  endfunction

  // --------------------------------------------------------------------------
  // Store access
  // --------------------------------------------------------------------------
  assign wr_in_range = (32'(sample_pos_i) < MAX_LEN);

  always_ff @(posedge clk_i) begin
    if (cmd_i.mem_wr && wr_in_range) begin
      seq_mem_q[IDX_W'(sample_pos_i)] <= sample_value_i;
    end
    rd_data_q <= seq_mem_q[cmd_i.rd_hi ? idx1_q : idx0_q];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      h_q <= start_pos_i;
      w_q <= end_pos_i;
      c_q <= point_index_i;
    end
  end

  assign masked             = (h_q > w_q);
  assign status_o.masked    = masked;
  assign status_o.cmd_query = (in_cmd_i == pcfs_pkg::CMD_QUERY);

  // --------------------------------------------------------------------------
  // Region select: step and point count minus one for the chosen region
  // --------------------------------------------------------------------------
  always_comb begin
    sc_sum   = {1'b0, cfg_i.start_points} + {1'b0, cfg_i.center_points};
    in_start = (c_q < {1'b0, cfg_i.start_points});
    in_end   = (c_q >= sc_sum);
    end_m    = (cfg_i.end_points == '0) ? '0 : cfg_i.end_points - 1'b1;
    end_raw  = c_q - sc_sum;
    // Indices past the last point stick to the final end point.
    end_step = (end_raw > {1'b0, end_m}) ? end_m : end_raw[CW-1:0];
    ctx_step = in_start ? c_q[CW-1:0] : end_step;
    ctx_m    = in_start ? (cfg_i.start_points - 1'b1) : end_m;
    ctr_raw  = c_q - {1'b0, cfg_i.start_points};
    ctr_step = ctr_raw[CW-1:0];
    ctr_m    = cfg_i.center_points - 1'b1;
    span     = w_q - h_q;
    flen     = {1'b0, span} + 1'b1;
    twos     = $signed({1'b0, ctx_step, 1'b0}) - $signed({2'b00, ctx_m});
    den5     = {3'b000, ctx_m} + {1'b0, ctx_m, 2'b00};

    if (in_start || in_end) begin
      mul_a_d = flen;
      base_d  = in_start ? h_q : w_q;
      if (ctx_m == '0) begin
        // Single-point context region samples one fifth of the length back from its base.
        mul_b_d = -MW'(1);
        den_d   = CTX_DEN;
      end else begin
        mul_b_d = twos;
        den_d   = den5;
      end
    end else begin
      base_d = h_q;
      if (ctr_m == '0) begin
        mul_a_d = '0;
        mul_b_d = '0;
        den_d   = UNIT_DEN;
      end else begin
        mul_a_d = {1'b0, span};
        mul_b_d = $signed({2'b00, ctr_step});
        den_d   = {3'b000, ctr_m};
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.sel_en) begin
      mul_a_q <= mul_a_d;
      mul_b_q <= mul_b_d;
      den_q   <= den_d;
      base_q  <= base_d;
    end
  end

  // --------------------------------------------------------------------------
  // Numerator magnitude and rounding bias. round(a/b) with ties upward is
  // floor((2a+b)/(2b)); for negative a this becomes -floor((2|a|+b-1)/(2b)).
  // --------------------------------------------------------------------------
  always_comb begin
    prod_k   = $signed({1'b0, mul_a_q}) * mul_b_q;
    neg_k    = prod_k[KW-1];
    mag_k    = neg_k ? KW'(-prod_k) : KW'(prod_k);
    dividend = {mag_k[NW-FW-2:0], {(FW+1){1'b0}}} + NW'(den_q) - NW'(neg_k);
  end

  // Two restoring steps per cycle.
  always_comb begin
    logic [DW:0] t;
    div_d = div_q;
    rem_d = rem_q;
    for (int i = 0; i < 2; i++) begin
      t     = {rem_d, div_d[NW-1]};
      div_d = {div_d[NW-2:0], 1'b0};
      if (t >= {1'b0, d2_q}) begin
        t        = t - {1'b0, d2_q};
        div_d[0] = 1'b1;
      end
      rem_d = t[DW-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.mul_en) begin
      div_q <= dividend;
      rem_q <= '0;
      d2_q  <= {den_q, 1'b0};
      neg_q <= neg_k;
    end else if (cmd_i.div_en) begin
      div_q <= div_d;
      rem_q <= rem_d;
    end
  end

  // --------------------------------------------------------------------------
  // Sample position, neighbor indices clamped into the valid length
  // --------------------------------------------------------------------------
  always_comb begin
    base_ext = $signed({{(IW-PW){1'b0}}, base_q, {FW{1'b0}}});
    q_ext    = $signed({2'b00, div_q[POSW-3:0]});
    pos      = neg_q ? (base_ext - q_ext) : (base_ext + q_ext);
    l0       = pos[POSW-1:FW];
    l1       = l0 + 1'b1;
    lim      = (32'(cfg_i.seq_length) > MAX_LEN) ? LW'(MAX_LEN) : cfg_i.seq_length;
    last     = (lim == '0) ? '0 : lim - 1'b1;
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.pos_en) begin
      idx0_q <= IDX_W'(clamp_idx(l0, last));
      idx1_q <= IDX_W'(clamp_idx(l1, last));
      f_q    <= pos[FW-1:0];
    end
    if (cmd_i.s0_en) begin
      s0_q <= rd_data_q;
    end
    if (cmd_i.mac_en) begin
      mac_q <= prod_f;
    end
  end

  // --------------------------------------------------------------------------
  // (1-f)*s0 + f*s1 = s0 + f*(s1-s0), rounded half up and saturated
  // --------------------------------------------------------------------------
  always_comb begin
    diff   = $signed({rd_data_q[SW-1], rd_data_q}) - $signed({s0_q[SW-1], s0_q});
    prod_f = $signed({1'b0, f_q}) * diff;
    acc    = $signed({{(ACCW-SW-FW){s0_q[SW-1]}}, s0_q, {FW{1'b0}}})
           + $signed({mac_q[PRODW-1], mac_q})
           + $signed(ACCW'(1) << (FW - 1));
    res_hi = acc[ACCW-1:FW];
    if (res_hi > $signed(RESW'(2 ** (SW - 1) - 1))) begin
      res_sat = {1'b0, {(SW-1){1'b1}}};
    end else if (res_hi < -$signed(RESW'(2 ** (SW - 1)))) begin
      res_sat = {1'b1, {(SW-1){1'b0}}};
    end else begin
      res_sat = res_hi[SW-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      result_value_o <= masked ? '0 : res_sat;
      masked_o       <= masked;
    end
  end

endmodule

[rtl/proposal_context_feature_sampler.sv]
// ----------------------------------------------------------------------------
// proposal_context_feature_sampler
// Top level: APB register file, query sequencer and sampling datapath.
// ----------------------------------------------------------------------------
// A sample write (cmd 0) is stored on acceptance and the block stays ready.
// A query (cmd 1) is worked on alone: region select, multiply, iterative
// divide, index calculation, two store reads, interpolation and the load
// of the output register, which waits until that register is free. The
// divider resolves two quotient bits of a 32-bit dividend per cycle. An
// inverted proposal (start after end) skips the arithmetic. One finished
// result may wait in the output register while the next item is accepted.
// The sequence store holds whatever was written and is not cleared by reset.
module proposal_context_feature_sampler #(
  parameter int unsigned MAX_LEN = 128
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  pcfs_in_if.sink                             req_i,
  pcfs_out_if.source                          rsp_o,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [pcfs_pkg::APB_ADDR_W-1:0]     paddr,
  input  logic [pcfs_pkg::APB_DATA_W-1:0]     pwdata,
  output logic [pcfs_pkg::APB_DATA_W-1:0]     prdata,
  output logic                                pready
);

  pcfs_pkg::cfg_t       cfg_q;
  pcfs_pkg::reg_idx_e   reg_idx;
  pcfs_pkg::dp_cmd_t    dp_cmd;
  pcfs_pkg::dp_status_t dp_status;
  logic                 cfg_wr;

  // --------------------------------------------------------------------------
  // Configuration registers
  // --------------------------------------------------------------------------
  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign reg_idx = pcfs_pkg::reg_idx_e'(paddr[3:2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.seq_length    <= pcfs_pkg::SEQ_LENGTH_RST;
      cfg_q.start_points  <= pcfs_pkg::START_POINTS_RST;
      cfg_q.center_points <= pcfs_pkg::CENTER_POINTS_RST;
      cfg_q.end_points    <= pcfs_pkg::END_POINTS_RST;
    end else if (cfg_wr) begin
      unique case (reg_idx)
        pcfs_pkg::REG_SEQ_LENGTH: begin
          cfg_q.seq_length <= pwdata[pcfs_pkg::LEN_W-1:0];
        end
        pcfs_pkg::REG_START_POINTS: begin
          cfg_q.start_points <= pwdata[pcfs_pkg::CNT_W-1:0];
        end
        pcfs_pkg::REG_CENTER_POINTS: begin
          cfg_q.center_points <= pwdata[pcfs_pkg::CNT_W-1:0];
        end
        pcfs_pkg::REG_END_POINTS: begin
          cfg_q.end_points <= pwdata[pcfs_pkg::CNT_W-1:0];
        end
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      pcfs_pkg::REG_SEQ_LENGTH:    prdata = pcfs_pkg::APB_DATA_W'(cfg_q.seq_length);
      pcfs_pkg::REG_START_POINTS:  prdata = pcfs_pkg::APB_DATA_W'(cfg_q.start_points);
      pcfs_pkg::REG_CENTER_POINTS: prdata = pcfs_pkg::APB_DATA_W'(cfg_q.center_points);
      pcfs_pkg::REG_END_POINTS:    prdata = pcfs_pkg::APB_DATA_W'(cfg_q.end_points);
      default:                     prdata = '0;
    endcase
  end

  // --------------------------------------------------------------------------
  // Sequencer and datapath
  // --------------------------------------------------------------------------
  pcfs_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (req_i.valid),
    .in_ready_o  (req_i.ready),
    .out_valid_o (rsp_o.valid),
    .out_ready_i (rsp_o.ready),
    .status_i    (dp_status),
    .cmd_o       (dp_cmd)
  );

  pcfs_datapath #(
    .MAX_LEN (MAX_LEN)
  ) u_datapath (
    .clk_i          (clk_i),
    .cfg_i          (cfg_q),
    .cmd_i          (dp_cmd),
    .status_o       (dp_status),
    .in_cmd_i       (req_i.cmd),
    .sample_value_i (req_i.sample_value),
    .sample_pos_i   (req_i.sample_pos),
    .start_pos_i    (req_i.start_pos),
    .end_pos_i      (req_i.end_pos),
    .point_index_i  (req_i.point_index),
    .result_value_o (rsp_o.result_value),
    .masked_o       (rsp_o.masked)
  );

endmodule

[rtl/pcfs_checker.sv]
// ----------------------------------------------------------------------------
// pcfs_checker
// Port-level assertions for the proposal context feature sampler, bound to
// the top level.
// ----------------------------------------------------------------------------
module pcfs_checker (
  input logic                                 clk_i,
  input logic                                 rst_ni,
  input logic                                 req_valid_i,
  input logic                                 req_ready_i,
  input logic                                 req_cmd_i,
  input logic                                 rsp_valid_i,
  input logic                                 rsp_ready_i,
  input logic signed [pcfs_pkg::SAMPLE_W-1:0] rsp_result_value_i,
  input logic                                 rsp_masked_i
);

  // A masked result always carries a zero value.
  a_masked_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && rsp_masked_i |-> rsp_result_value_i == '0)
    else $error("masked beat with nonzero result");

  // A stalled result beat stays offered.
  a_rsp_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && !rsp_ready_i |=> rsp_valid_i)
    else $error("result beat dropped while stalled");

  // A query occupies the block, so the next beat cannot follow directly.
  a_query_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_valid_i && req_ready_i && req_cmd_i == pcfs_pkg::CMD_QUERY |=> !req_ready_i)
    else $error("input accepted in the cycle after a query");

  // A sample write leaves the block ready for the next beat.
  a_write_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_valid_i && req_ready_i && req_cmd_i == pcfs_pkg::CMD_WRITE |=> req_ready_i)
    else $error("block busy after a sample write");

endmodule

bind proposal_context_feature_sampler pcfs_checker u_pcfs_checker (
  .clk_i              (clk_i),
  .rst_ni             (rst_ni),
  .req_valid_i        (req_i.valid),
  .req_ready_i        (req_i.ready),
  .req_cmd_i          (req_i.cmd),
  .rsp_valid_i        (rsp_o.valid),
  .rsp_ready_i        (rsp_o.ready),
  .rsp_result_value_i (rsp_o.result_value),
  .rsp_masked_i       (rsp_o.masked)
);

[bench/proposal_context_feature_sampler_tb.sv]
// ----------------------------------------------------------------------------
// proposal_context_feature_sampler_tb
// Self-checking bench for the proposal context feature sampler. The sequence
// store is filled first, then directed and random sample writes and point
// queries run under several register settings. A scoreboard predicts every
// interpolated feature and checks each output beat in order. Both channels
// idle at random, and the output side is held off for a long stretch once.
// ----------------------------------------------------------------------------
module proposal_context_feature_sampler_tb;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int     SAMPLE_W     = pcfs_pkg::SAMPLE_W;
  localparam int     POS_W        = pcfs_pkg::POS_W;
  localparam int     POINT_W      = pcfs_pkg::POINT_W;
  localparam int     LEN_W        = pcfs_pkg::LEN_W;
  localparam int     CNT_W        = pcfs_pkg::CNT_W;
  localparam int     APB_DATA_W   = pcfs_pkg::APB_DATA_W;
  localparam int     APB_ADDR_W   = pcfs_pkg::APB_ADDR_W;

  localparam int     CLK_PERIOD   = 8;
  localparam int     SEQ_DEPTH    = 128;
  localparam int     PHASES       = 10;
  localparam int     PHASE_ITEMS  = 105;
  localparam longint POS_ONE      = longint'(1) << pcfs_pkg::FRAC_W;

  typedef struct {
    logic                       cmd;
    logic signed [SAMPLE_W-1:0] sample_value;
    logic [POS_W-1:0]           sample_pos;
    logic [POS_W-1:0]           start_pos;
    logic [POS_W-1:0]           end_pos;
    logic [POINT_W-1:0]         point_index;
  } req_beat_t;

  typedef struct {
    logic signed [SAMPLE_W-1:0] value;
    logic                       masked;
  } feature_t;

  class feature_scoreboard;
    logic signed [SAMPLE_W-1:0] samples [SEQ_DEPTH];
    logic [LEN_W-1:0]           seq_length;
    logic [CNT_W-1:0]           start_points;
    logic [CNT_W-1:0]           center_points;
    logic [CNT_W-1:0]           end_points;
    feature_t                   expected_q [$];
    int                         n_writes;
    int                         n_queries;
    int                         n_masked;
    int                         n_checked;
    int                         n_errors;

    function new();
      seq_length    = pcfs_pkg::SEQ_LENGTH_RST;
      start_points  = pcfs_pkg::START_POINTS_RST;
      center_points = pcfs_pkg::CENTER_POINTS_RST;
      end_points    = pcfs_pkg::END_POINTS_RST;
    endfunction

    function void set_reg(pcfs_pkg::reg_idx_e idx, logic [APB_DATA_W-1:0] data);
      case (idx)
        pcfs_pkg::REG_SEQ_LENGTH:    seq_length    = data[LEN_W-1:0];
        pcfs_pkg::REG_START_POINTS:  start_points  = data[CNT_W-1:0];
        pcfs_pkg::REG_CENTER_POINTS: center_points = data[CNT_W-1:0];
        default:                     end_points    = data[CNT_W-1:0];
      endcase
    endfunction

    function logic [APB_DATA_W-1:0] reg_value(pcfs_pkg::reg_idx_e idx);
      case (idx)
        pcfs_pkg::REG_SEQ_LENGTH:    return APB_DATA_W'(seq_length);
        pcfs_pkg::REG_START_POINTS:  return APB_DATA_W'(start_points);
        pcfs_pkg::REG_CENTER_POINTS: return APB_DATA_W'(center_points);
        default:                     return APB_DATA_W'(end_points);
      endcase
    endfunction

    function longint floor_quot(longint a, longint b);
      longint q;
      q = a / b;
      if ((a % b) != 0 && a < 0) q--;
      return q;
    endfunction

    // Nearest, with ties going upward.
    function longint round_quot(longint a, longint b);
      return floor_quot(2 * a + b, 2 * b);
    endfunction

    function longint sample_at(longint i, longint len);
      if (i < 0) i = 0;
      if (i > len - 1) i = len - 1;
      return longint'(samples[i]);
    endfunction

    function void note_beat(req_beat_t b);
      longint   h, w, c, len, pos, base, step, m, span, l, f, acc, res;
      longint   s_n, c_n, e_n;
      feature_t r;
      if (b.cmd == pcfs_pkg::CMD_WRITE) begin
        samples[b.sample_pos] = b.sample_value;
        n_writes++;
        return;
      end
      n_queries++;
      h = longint'(b.start_pos);
      w = longint'(b.end_pos);
      c = longint'(b.point_index);
      if (h > w) begin
        r.value  = '0;
        r.masked = 1'b1;
        n_masked++;
        expected_q.push_back(r);
        return;
      end
      len = longint'(seq_length);
      if (len < 1) len = 1;
      if (len > SEQ_DEPTH) len = SEQ_DEPTH;
      s_n = longint'(start_points);
      c_n = longint'(center_points);
      e_n = longint'(end_points);
      if (c < s_n || c >= s_n + c_n) begin
        // Context regions span 2/5 of the proposal, centered on h or on w.
        span = w - h + 1;
        if (c < s_n) begin
          base = h;
          step = c;
          m    = s_n - 1;
        end else begin
          base = w;
          step = c - (s_n + c_n);
          m    = (e_n > 0) ? e_n - 1 : 0;
          if (step > m) step = m;
        end
        if (m <= 0) pos = base * POS_ONE + round_quot(-span * POS_ONE, 5);
        else pos = base * POS_ONE + round_quot(span * (2 * step - m) * POS_ONE, 5 * m);
      end else begin
        step = c - s_n;
        m    = c_n - 1;
        if (m <= 0) pos = h * POS_ONE;
        else pos = h * POS_ONE + round_quot(step * (w - h) * POS_ONE, m);
      end
      l   = floor_quot(pos, POS_ONE);
      f   = pos - l * POS_ONE;
      acc = (POS_ONE - f) * sample_at(l, len) + f * sample_at(l + 1, len);
      res = floor_quot(acc + POS_ONE / 2, POS_ONE);
      if (res > 32767) res = 32767;
      if (res < -32768) res = -32768;
      r.value  = res[SAMPLE_W-1:0];
      r.masked = 1'b0;
      expected_q.push_back(r);
    endfunction

    function void check_beat(logic signed [SAMPLE_W-1:0] value, logic masked);
      feature_t e;
      if (expected_q.size() == 0) begin
        $display("%0t: result with none expected: value %0d masked %0b",
                 $time, value, masked);
        n_errors++;
        return;
      end
      e = expected_q.pop_front();
      n_checked++;
      if (value !== e.value) begin
        $display("%0t: result_value expected %0d actual %0d", $time, e.value, value);
        n_errors++;
      end
      if (masked !== e.masked) begin
        $display("%0t: masked expected %0b actual %0b", $time, e.masked, masked);
        n_errors++;
      end
    endfunction
  endclass

  logic                  clk_i = 1'b0;
  logic                  rst_ni;
  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [APB_ADDR_W-1:0] paddr;
  logic [APB_DATA_W-1:0] pwdata;
  logic [APB_DATA_W-1:0] prdata;
  logic                  pready;

  pcfs_in_if  req_if ();
  pcfs_out_if rsp_if ();

  feature_scoreboard board;
  int                idle_pct = 36;
  int                rsp_hold = 0;
  int                n_settings = 0;

  proposal_context_feature_sampler DUT (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .req_i   (req_if),
    .rsp_o   (rsp_if),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  always #(CLK_PERIOD / 2) clk_i = ~clk_i;

  function automatic req_beat_t rand_beat();
    req_beat_t b;
    b.cmd          = pcfs_pkg::CMD_QUERY;
    b.sample_value = SAMPLE_W'($urandom());
    b.sample_pos   = POS_W'($urandom());
    b.start_pos    = POS_W'($urandom());
    b.end_pos      = POS_W'($urandom());
    b.point_index  = POINT_W'($urandom());
    return b;
  endfunction

  function automatic req_beat_t write_beat(int unsigned at, logic [SAMPLE_W-1:0] value);
    req_beat_t b;
    b              = rand_beat();
    b.cmd          = pcfs_pkg::CMD_WRITE;
    b.sample_pos   = POS_W'(at);
    b.sample_value = value;
    return b;
  endfunction

  function automatic req_beat_t query_beat(int unsigned h, int unsigned w, int unsigned pt);
    req_beat_t b;
    b             = rand_beat();
    b.start_pos   = POS_W'(h);
    b.end_pos     = POS_W'(w);
    b.point_index = POINT_W'(pt);
    return b;
  endfunction

  // Mostly well-formed queries inside the valid sequence; the rest are writes
  // and unconstrained queries, which also cover inverted proposals.
  function automatic req_beat_t make_beat();
    req_beat_t   b;
    int unsigned len_eff;
    int unsigned total;
    b = rand_beat();
    if ($urandom_range(99, 0) < 25) begin
      b.cmd = pcfs_pkg::CMD_WRITE;
    end else if ($urandom_range(99, 0) < 75) begin
      len_eff = 32'(board.seq_length);
      if (len_eff < 1) len_eff = 1;
      if (len_eff > SEQ_DEPTH) len_eff = SEQ_DEPTH;
      total = 32'(board.start_points) + 32'(board.center_points)
            + 32'(board.end_points);
      b.start_pos = POS_W'($urandom_range(len_eff - 1, 0));
      b.end_pos   = POS_W'($urandom_range(len_eff - 1, 32'(b.start_pos)));
      if (total == 0) b.point_index = POINT_W'($urandom_range(255, 0));
      else b.point_index = POINT_W'($urandom_range((total > 256) ? 255 : total - 1, 0));
    end
    return b;
  endfunction

  function automatic logic [LEN_W-1:0] pick_length();
    case ($urandom_range(9, 0))
      0:       return 8'd0;
      1:       return 8'd1;
      2:       return LEN_W'(SEQ_DEPTH);
      3:       return 8'd255;
      default: return LEN_W'($urandom_range(SEQ_DEPTH, 2));
    endcase
  endfunction

  function automatic logic [CNT_W-1:0] pick_points();
    case ($urandom_range(9, 0))
      0:       return 7'd0;
      1:       return 7'd1;
      2:       return 7'd64;
      3:       return 7'd127;
      default: return CNT_W'($urandom_range(64, 2));
    endcase
  endfunction

  task automatic offer(input req_beat_t b);
    while ($urandom_range(99, 0) < idle_pct) begin
      req_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    req_if.valid        <= 1'b1;
    req_if.cmd          <= b.cmd;
    req_if.sample_value <= b.sample_value;
    req_if.sample_pos   <= b.sample_pos;
    req_if.start_pos    <= b.start_pos;
    req_if.end_pos      <= b.end_pos;
    req_if.point_index  <= b.point_index;
    do @(posedge clk_i); while (!req_if.ready);
    board.note_beat(b);
  endtask

  // Waits until every expected result is out, then waits on so that a
  // trailing sample write also finishes and the block is left idle.
  task automatic drain();
    req_if.valid <= 1'b0;
    while (board.expected_q.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic program_reg(input pcfs_pkg::reg_idx_e idx,
                             input logic [APB_DATA_W-1:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    board.set_reg(idx, data);
    // Read the register back in a second transfer.
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    if (prdata !== board.reg_value(idx)) begin
      $display("%0t: register %s read expected %0d actual %0d",
               $time, idx.name(), board.reg_value(idx), prdata);
      board.n_errors++;
    end
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic program_all(input pcfs_pkg::cfg_t cfg);
    program_reg(pcfs_pkg::REG_SEQ_LENGTH, APB_DATA_W'(cfg.seq_length));
    program_reg(pcfs_pkg::REG_START_POINTS, APB_DATA_W'(cfg.start_points));
    program_reg(pcfs_pkg::REG_CENTER_POINTS, APB_DATA_W'(cfg.center_points));
    program_reg(pcfs_pkg::REG_END_POINTS, APB_DATA_W'(cfg.end_points));
    n_settings++;
  endtask

  // Output side: checks each accepted beat and chooses ready for the next.
  initial begin
    rsp_if.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (rst_ni && rsp_if.valid && rsp_if.ready)
        board.check_beat(rsp_if.result_value, rsp_if.masked);
      if (rsp_hold > 0) begin
        rsp_if.ready <= 1'b0;
        rsp_hold--;
      end else begin
        rsp_if.ready <= ($urandom_range(99, 0) >= idle_pct);
      end
    end
  end

  initial begin
    #4_000_000;
    $display("proposal_context_feature_sampler verification failed");
    $finish;
  end

  initial begin
    pcfs_pkg::cfg_t cfg;
    board                = new();
    rst_ni              <= 1'b0;
    psel                <= 1'b0;
    penable             <= 1'b0;
    pwrite              <= 1'b0;
    paddr               <= '0;
    pwdata              <= '0;
    req_if.valid        <= 1'b0;
    req_if.cmd          <= pcfs_pkg::CMD_WRITE;
    req_if.sample_value <= '0;
    req_if.sample_pos   <= '0;
    req_if.start_pos    <= '0;
    req_if.end_pos      <= '0;
    req_if.point_index  <= '0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Every entry gets written before any query can read it.
    for (int i = 0; i < SEQ_DEPTH; i++) offer(write_beat(i, SAMPLE_W'($urandom())));

    // Directed beats under the reset settings (8 start, 16 center, 8 end).
    offer(write_beat(0, 16'h7FFF));
    offer(write_beat(1, 16'h8000));
    offer(write_beat(127, 16'hFFFF));
    offer(write_beat(99, 16'h0100));
    offer(query_beat(127, 0, 0));
    offer(query_beat(5, 4, 10));
    offer(query_beat(0, 0, 0));
    offer(query_beat(0, 127, 7));
    offer(query_beat(0, 127, 8));
    offer(query_beat(0, 127, 23));
    offer(query_beat(0, 127, 24));
    offer(query_beat(0, 127, 31));
    offer(query_beat(10, 20, 255));
    offer(query_beat(10, 20, 191));
    offer(query_beat(0, 1, 3));
    offer(write_beat(2, 16'h4000));
    offer(query_beat(110, 120, 12));
    offer(query_beat(127, 127, 20));
    offer(query_beat(50, 60, 15));
    drain();

    for (int p = 0; p < PHASES; p++) begin
      case (p)
        0: cfg = '{seq_length: 8'd128, start_points: 7'd1,
                   center_points: 7'd1, end_points: 7'd1};
        1: cfg = '{seq_length: 8'd1, start_points: 7'd64,
                   center_points: 7'd64, end_points: 7'd64};
        2: cfg = '{seq_length: 8'd0, start_points: 7'd0,
                   center_points: 7'd0, end_points: 7'd0};
        3: cfg = '{seq_length: 8'd255, start_points: 7'd127,
                   center_points: 7'd127, end_points: 7'd127};
        default: begin
          cfg.seq_length    = pick_length();
          cfg.start_points  = pick_points();
          cfg.center_points = pick_points();
          cfg.end_points    = pick_points();
        end
      endcase
      program_all(cfg);
      idle_pct = (p == 5) ? 0 : 36;
      if (p == 6) rsp_hold = 400;
      for (int n = 0; n < PHASE_ITEMS; n++) offer(make_beat());
      drain();
    end

    repeat (30) @(posedge clk_i);
    $display("Covered %0d sample writes and %0d queries (%0d masked) over %0d settings;",
             board.n_writes, board.n_queries, board.n_masked, n_settings);
    $display("%0d result beats checked, %0d mismatches.", board.n_checked, board.n_errors);
    if (board.n_errors == 0 && board.expected_q.size() == 0) begin
      $display("proposal_context_feature_sampler verification clean");
    end else begin
      $display("proposal_context_feature_sampler verification failed");
    end
    $finish;
  end

endmodule
